// ===== rtl/bls_pkg.sv =====
// Shared constants, codes and control types for the bounded LIFO stack.
package bls_pkg;

    // Storage geometry
    localparam int DEPTH  = 256;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int LIM_W  = 9;
    localparam int POS_W  = 9;
    localparam int WORD_W = 32;
    localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;

    // Operation codes
    localparam logic [1:0] OP_PUSH = 2'd0;
    localparam logic [1:0] OP_POP  = 2'd1;
    localparam logic [1:0] OP_PEEK = 2'd2;
    localparam logic [1:0] OP_TOP  = 2'd3;

    // Result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [1:0] ST_UNDERFLOW = 2'd2;
    localparam logic [1:0] ST_BADPOS    = 2'd3;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic accept;    // input transfer this cycle: execute the operation
        logic load_out;  // capture the finished result into the output register
    } bls_cmd_t;

endpackage

// ===== rtl/bls_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module bls_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write and registered read
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/bls_ctrl.sv =====
// Controller state machine: input acceptance, execute step and output handoff.
module bls_ctrl import bls_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_tvalid,
    output logic     s_tready,
    output logic     m_tvalid,
    input  logic     m_tready,
    output bls_cmd_t cmd
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic state_reg, state_next;
    logic out_valid_reg, out_valid_next;
    logic out_free;

    // Take no input transfer while reset is held
    assign s_tready = aresetn && (state_reg == S_IDLE);
    assign out_free = !out_valid_reg || m_tready;

    // Decode commands and next state
    always_comb begin
        state_next   = state_reg;
        cmd.accept   = 1'b0;
        cmd.load_out = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid && s_tready) begin
                    cmd.accept = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                if (out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Hold the output valid until the result transfer completes
    always_comb begin
        if (cmd.load_out) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_tvalid = out_valid_reg;

endmodule

// ===== rtl/bls_dp.sv =====
// Datapath: entry count, limit register, stack memory and result register.
module bls_dp import bls_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  bls_cmd_t          cmd,
    input  logic              cfg_we,
    input  logic [LIM_W-1:0]  cfg_wdata,
    input  logic [1:0]        in_func,
    input  logic [WORD_W-1:0] in_push_value,
    input  logic [POS_W-1:0]  in_peek_position,
    output logic [WORD_W-1:0] out_read_value,
    output logic [1:0]        out_status,
    output logic              out_is_empty,
    output logic              out_is_full
);

    // Source of the result word
    localparam logic [1:0] VAL_ZERO = 2'd0;
    localparam logic [1:0] VAL_NONE = 2'd1;
    localparam logic [1:0] VAL_RAM  = 2'd2;

    logic [CNT_W-1:0]  count_reg, count_next;
    logic [LIM_W-1:0]  limit_reg;
    logic [LIM_W-1:0]  lim_clamp;
    logic [CNT_W-1:0]  lim_eff;
    logic [CMP_W-1:0]  count_ext, pos_ext, peek_diff;
    logic [ADDR_W-1:0] wr_addr, rd_addr;
    logic              wr_en, rd_en;
    logic [1:0]        kind_comb, status_comb;
    logic [WORD_W-1:0] ram_rdata;

    logic [1:0]        kind_reg;
    logic [1:0]        status_reg;
    logic              empty_reg, full_reg;
    logic [WORD_W-1:0] rv_out_reg;
    logic [1:0]        st_out_reg;
    logic              empty_out_reg, full_out_reg;

    // Clamp the configured limit into 1..DEPTH
    always_comb begin
        if (limit_reg == '0) begin
            lim_clamp = LIM_W'(1);
        end else if (limit_reg > LIM_W'(DEPTH)) begin
            lim_clamp = LIM_W'(DEPTH);
        end else begin
            lim_clamp = limit_reg;
        end
    end
    assign lim_eff = CNT_W'(lim_clamp);

    assign count_ext = CMP_W'(count_reg);
    assign pos_ext   = CMP_W'(in_peek_position);
    assign peek_diff = count_ext - pos_ext;

    // Decode the operation against the current count
    always_comb begin
        count_next  = count_reg;
        wr_en       = 1'b0;
        rd_en       = 1'b0;
        wr_addr     = count_reg[ADDR_W-1:0];
        rd_addr     = ADDR_W'(count_reg - CNT_W'(1));
        kind_comb   = VAL_ZERO;
        status_comb = ST_OK;
        unique case (in_func)
            OP_PUSH: begin
                if (count_reg >= lim_eff) begin
                    status_comb = ST_OVERFLOW;
                end else begin
                    wr_en      = cmd.accept;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            OP_POP: begin
                if (count_reg == '0) begin
                    kind_comb   = VAL_NONE;
                    status_comb = ST_UNDERFLOW;
                end else begin
                    rd_en      = cmd.accept;
                    kind_comb  = VAL_RAM;
                    count_next = count_reg - CNT_W'(1);
                end
            end
            OP_PEEK: begin
                rd_addr = peek_diff[ADDR_W-1:0];
                if (pos_ext == '0 || pos_ext > count_ext) begin
                    kind_comb   = VAL_NONE;
                    status_comb = ST_BADPOS;
                end else begin
                    rd_en     = cmd.accept;
                    kind_comb = VAL_RAM;
                end
            end
            OP_TOP: begin
                if (count_reg == '0) begin
                    kind_comb = VAL_NONE;
                end else begin
                    rd_en     = cmd.accept;
                    kind_comb = VAL_RAM;
                end
            end
            default: kind_comb = VAL_ZERO;
        endcase
    end

    // Stack storage
    bls_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (in_push_value),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    // Control state: count and limit
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            limit_reg <= LIM_W'(256);
        end else begin
            if (cmd.accept) begin
                count_reg <= count_next;
            end
            if (cfg_we) begin
                limit_reg <= cfg_wdata;
            end
        end
    end

    // Hold the pending result while the memory read completes
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            kind_reg   <= kind_comb;
            status_reg <= status_comb;
            empty_reg  <= (count_next == '0);
            full_reg   <= (count_next >= lim_eff);
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            case (kind_reg)
                VAL_RAM:  rv_out_reg <= ram_rdata;
                VAL_NONE: rv_out_reg <= '1;
                default:  rv_out_reg <= '0;
            endcase
            st_out_reg    <= status_reg;
            empty_out_reg <= empty_reg;
            full_out_reg  <= full_reg;
        end
    end

    assign out_read_value = rv_out_reg;
    assign out_status     = st_out_reg;
    assign out_is_empty   = empty_out_reg;
    assign out_is_full    = full_out_reg;

endmodule

// ===== rtl/bounded_lifo_stack.sv =====
// Top level of the bounded LIFO stack: stream ports, controller and datapath.
//
// Bounded LIFO stack of signed 32-bit words held in a 256-entry RAM. Each input
// transfer carries one operation (push, pop, peek at a 1-based position from
// the top, read top) and yields exactly one result transfer with the word read,
// a status code and empty/full flags. An operation updates the entry count and
// issues the RAM access, then the registered RAM read lands in the output
// register once the output side is free; no new input is taken until the
// result is loaded. The output register holds a result until it is taken.
// The stack limit is written through cfg_we/cfg_wdata; the user must write it
// only while idle, and the block itself does not enforce this. 0 acts as 1
// and values above 256 act as 256. No clearing pass is needed after reset.
module bounded_lifo_stack import bls_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration: stack_limit
    input  logic        cfg_we,
    input  logic [8:0]  cfg_wdata,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // [31:0] push_value, [40:32] peek_position, rest zero
    input  logic [1:0]  s_tuser,   // [1:0] func
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [31:0] read_value, [32] is_empty, [33] is_full, rest zero
    output logic [1:0]  m_tuser    // [1:0] status
);

    bls_cmd_t          cmd;
    logic [WORD_W-1:0] read_value;
    logic [1:0]        status;
    logic              is_empty, is_full;

    bls_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    bls_dp u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .cfg_we           (cfg_we),
        .cfg_wdata        (cfg_wdata),
        .in_func          (s_tuser),
        .in_push_value    (s_tdata[31:0]),
        .in_peek_position (s_tdata[40:32]),
        .out_read_value   (read_value),
        .out_status       (status),
        .out_is_empty     (is_empty),
        .out_is_full      (is_full)
    );

    // Pack the result fields
    assign m_tdata = {6'b0, is_full, is_empty, read_value};
    assign m_tuser = status;

endmodule
